[hdl/skl_pkg.sv]
// Shared constants, types and helper functions of the leg kinematics pipeline.
package skl_pkg;

    localparam int Q_PI         = 205887;
    localparam int Q_TWO_PI     = 411775;
    localparam int Q_HALF_PI    = 102944;
    localparam int Q_MS_CENTRE  = 98304;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 652032874;

    localparam int ANG_W   = 24;
    localparam int XY_W    = 33;
    localparam int Z_W     = 20;
    localparam int LEN_W   = 14;
    localparam int POS_W   = 16;
    localparam int WRAP_UP = 6;

    localparam int LAT_ANG = 4;
    localparam int LAT_COR = CORDIC_STEPS + 1;
    localparam int LAT_CMB = 4;

    localparam logic [1:0] REG_FAR_LINK  = 2'd0;
    localparam logic [1:0] REG_NEAR_LINK = 2'd1;
    localparam logic [1:0] REG_HIP_OFS   = 2'd2;

    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic signed [XY_W-1:0]  t_xy;
    typedef logic [LEN_W-1:0]        t_len;
    typedef logic signed [POS_W-1:0] t_pos;

    function automatic logic [16:0] centre_offset(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:  v = 17'd104989;
            5'd1:  v = 17'd95224;
            5'd2:  v = 17'd110166;
            5'd3:  v = 17'd93651;
            5'd4:  v = 17'd88015;
            5'd5:  v = 17'd113246;
            5'd6:  v = 17'd86442;
            5'd7:  v = 17'd89588;
            5'd8:  v = 17'd113246;
            5'd9:  v = 17'd79299;
            5'd10: v = 17'd86442;
            5'd11: v = 17'd103612;
            5'd12: v = 17'd82379;
            5'd13: v = 17'd85983;
            5'd14: v = 17'd104989;
            5'd15: v = 17'd87491;
            5'd16: v = 17'd89588;
            5'd17: v = 17'd100860;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic int atan_q16(input int i);
        int v;
        unique case (i)
            0:  v = 51472;
            1:  v = 30386;
            2:  v = 16055;
            3:  v = 8150;
            4:  v = 4091;
            5:  v = 2047;
            6:  v = 1024;
            7:  v = 512;
            8:  v = 256;
            9:  v = 128;
            10: v = 64;
            11: v = 32;
            12: v = 16;
            13: v = 8;
            14: v = 4;
            15: v = 2;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Maps an angle in -3pi..13pi to -pi..pi with parallel compares at wrap points.
    function automatic t_angle wrap_angle(input t_angle a);
        int k;
        int v;
        k = 0;
        for (int j = 0; j < WRAP_UP; j++) begin
            if (int'(a) > Q_PI + j * Q_TWO_PI) k++;
        end
        if (int'(a) < -Q_PI) k--;
        v = int'(a) - k * Q_TWO_PI;
        return ANG_W'(v);
    endfunction

    function automatic t_pos sat16(input logic signed [21:0] v);
        t_pos r;
        if (v > 22'sd32767) r = 16'sh7FFF;
        else if (v < -22'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

endpackage

[hdl/skl_angles.sv]
// Pulse-to-angle conversion with centring offsets, wrapping and the alpha angle.
module skl_angles
    import skl_pkg::*;
#(
    parameter int NUM_LEGS   = 6,
    parameter int PULSE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2:0]            i_leg,
    input  logic [PULSE_BITS-1:0] i_pulse0,
    input  logic [PULSE_BITS-1:0] i_pulse1,
    input  logic [PULSE_BITS-1:0] i_pulse2,
    output t_angle                o_a1,
    output t_angle                o_alpha,
    output t_angle                o_a2
);

    logic [PULSE_BITS-1:0] pulse [3];
    logic signed [39:0]    r_prod [3];
    t_angle                r_ofs  [3];
    t_angle                r_wrap [3];
    logic [2:0]            r_leg;
    t_angle                r_alpha;
    t_angle                r_a1;
    t_angle                r_a2;
    logic                  leg_ok;

    assign pulse[0] = i_pulse0;
    assign pulse[1] = i_pulse1;
    assign pulse[2] = i_pulse2;
    assign leg_ok   = int'(r_leg) < NUM_LEGS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_leg <= i_leg;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_joint
        logic [20:0]        ms;
        logic signed [21:0] diff;
        logic signed [39:0] rnd;
        logic [16:0]        ofs;

        assign ms   = (21'(pulse[j]) * 21'd20) << (16 - PULSE_BITS);
        assign diff = $signed({1'b0, ms}) - 22'sd98304;
        assign rnd  = r_prod[j] + 40'sd32768;
        assign ofs  = leg_ok ? centre_offset(5'(r_leg) * 5'd3 + 5'(j)) : 17'd0;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[j] <= diff * 40'sd102944;
                r_ofs[j]  <= rnd[39:16] + t_angle'({7'b0, ofs});
                r_wrap[j] <= wrap_angle(r_ofs[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= wrap_angle(ANG_W'(Q_PI) - r_wrap[1] - r_wrap[0]);
            r_a1    <= r_wrap[1];
            r_a2    <= r_wrap[2];
        end
    end

    assign o_a1    = r_a1;
    assign o_alpha = r_alpha;
    assign o_a2    = r_a2;

endmodule

[hdl/skl_cordic.sv]
// Pipelined rotation-mode CORDIC giving sine and cosine of a wrapped angle.
module skl_cordic
    import skl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_angle i_angle,
    output t_xy    o_sin,
    output t_xy    o_cos
);

    t_xy                  r_x   [CORDIC_STEPS+1];
    t_xy                  r_y   [CORDIC_STEPS+1];
    logic signed [Z_W-1:0] r_z  [CORDIC_STEPS+1];
    logic                 r_neg [CORDIC_STEPS+1];
    t_angle               fold;
    logic                 fold_neg;

    // Angles beyond a quarter turn are rotated by pi and the result negated.
    always_comb begin
        fold     = i_angle;
        fold_neg = 1'b0;
        if (i_angle > ANG_W'(Q_HALF_PI)) begin
            fold     = i_angle - ANG_W'(Q_PI);
            fold_neg = 1'b1;
        end else if (i_angle < -ANG_W'(Q_HALF_PI)) begin
            fold     = i_angle + ANG_W'(Q_PI);
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= XY_W'(CORDIC_GAIN);
            r_y[0]   <= '0;
            r_z[0]   <= fold[Z_W-1:0];
            r_neg[0] <= fold_neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q16(i));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    assign o_sin = r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
    assign o_cos = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];

endmodule

[hdl/skl_combine.sv]
// Link-length products, planar sums, rotation about the hip and saturation.
module skl_combine
    import skl_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_xy  i_s1,
    input  t_xy  i_c1,
    input  t_xy  i_sa,
    input  t_xy  i_ca,
    input  t_xy  i_s2,
    input  t_xy  i_c2,
    input  t_len i_l0,
    input  t_len i_l1,
    input  t_len i_l2,
    output t_pos o_x,
    output t_pos o_y,
    output t_pos o_z
);

    localparam logic signed [47:0] HALF48 = 48'sd536870912;
    localparam logic signed [51:0] HALF52 = 52'sd536870912;

    logic signed [47:0] r_pc1, r_pca, r_ps1, r_psa;
    t_xy                r_s2a, r_c2a, r_s2b, r_c2b;
    logic signed [17:0] r_z, r_u, r_zb;
    logic signed [51:0] r_px, r_py;
    t_pos               r_x, r_y, r_zo;
    logic signed [47:0] qc1, qca, qs1, qsa;
    logic signed [51:0] qx, qy;
    logic signed [17:0] rc1, rca, rs1, rsa;

    assign qc1 = r_pc1 + HALF48;
    assign qca = r_pca + HALF48;
    assign qs1 = r_ps1 + HALF48;
    assign qsa = r_psa + HALF48;
    assign rc1 = qc1[47:30];
    assign rca = qca[47:30];
    assign rs1 = qs1[47:30];
    assign rsa = qsa[47:30];
    assign qx  = r_px + HALF52;
    assign qy  = r_py + HALF52;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc1 <= i_c1 * $signed({1'b0, i_l1});
            r_pca <= i_ca * $signed({1'b0, i_l0});
            r_ps1 <= i_s1 * $signed({1'b0, i_l1});
            r_psa <= i_sa * $signed({1'b0, i_l0});
            r_s2a <= i_s2;
            r_c2a <= i_c2;

            r_z   <= rc1 - rca;
            r_u   <= rs1 + rsa + $signed({4'b0, i_l2});
            r_s2b <= r_s2a;
            r_c2b <= r_c2a;

            r_px  <= r_s2b * r_u;
            r_py  <= r_c2b * r_u;
            r_zb  <= r_z;

            r_x   <= sat16(qx[51:30]);
            r_y   <= sat16(qy[51:30]);
            r_zo  <= sat16(22'(r_zb));
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_zo;

endmodule

[hdl/servo_pulse_leg_kinematics.sv]
// Top level of the servo pulse to foot position forward kinematics pipeline.
//
//  Channel   Signals                                  Direction
//  input     i_valid / o_stall, leg and three pulses  in
//  result    o_valid / i_stall, leg echo, x, y, z     out
//  config    i_cfg_valid / o_cfg_ready, index, data   in
//
// One transaction enters per cycle while no result is stalled; it passes the 4
// angle stages, the fold stage plus 16 CORDIC stages and 4 combine stages.
// Reset clears the valid bits and restores the link lengths.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module servo_pulse_leg_kinematics
    import skl_pkg::*;
#(
    parameter int NUM_LEGS   = 6,
    parameter int PULSE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_leg_number,
    input  logic [PULSE_BITS-1:0] i_pulse_joint0,
    input  logic [PULSE_BITS-1:0] i_pulse_joint1,
    input  logic [PULSE_BITS-1:0] i_pulse_joint2,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_leg_echo,
    output t_pos                  o_pos_x,
    output t_pos                  o_pos_y,
    output t_pos                  o_pos_z,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  t_len                  i_cfg_data
);

    localparam int TOTAL = LAT_ANG + LAT_COR + LAT_CMB;

    logic [TOTAL-1:0] r_vld;
    logic [2:0]       r_leg [TOTAL];
    t_len             r_far, r_near, r_hip;
    logic             adv;
    t_angle           a1, alpha, a2;
    t_xy              s1, c1, sa, ca, s2, c2;

    assign adv         = !(r_vld[TOTAL-1] && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far  <= 14'd8787;
            r_near <= 14'd5958;
            r_hip  <= 14'd2886;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FAR_LINK:  r_far  <= i_cfg_data;
                REG_NEAR_LINK: r_near <= i_cfg_data;
                REG_HIP_OFS:   r_hip  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[TOTAL-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_leg[0] <= i_leg_number;
            for (int k = 1; k < TOTAL; k++) r_leg[k] <= r_leg[k-1];
        end
    end

    skl_angles #(
        .NUM_LEGS   (NUM_LEGS),
        .PULSE_BITS (PULSE_BITS)
    ) u_angles (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_leg    (i_leg_number),
        .i_pulse0 (i_pulse_joint0),
        .i_pulse1 (i_pulse_joint1),
        .i_pulse2 (i_pulse_joint2),
        .o_a1     (a1),
        .o_alpha  (alpha),
        .o_a2     (a2)
    );

    skl_cordic u_cordic1 (.i_clk(i_clk), .i_en(adv), .i_angle(a1),    .o_sin(s1), .o_cos(c1));
    skl_cordic u_cordica (.i_clk(i_clk), .i_en(adv), .i_angle(alpha), .o_sin(sa), .o_cos(ca));
    skl_cordic u_cordic2 (.i_clk(i_clk), .i_en(adv), .i_angle(a2),    .o_sin(s2), .o_cos(c2));

    skl_combine u_combine (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_s1  (s1),
        .i_c1  (c1),
        .i_sa  (sa),
        .i_ca  (ca),
        .i_s2  (s2),
        .i_c2  (c2),
        .i_l0  (r_far),
        .i_l1  (r_near),
        .i_l2  (r_hip),
        .o_x   (o_pos_x),
        .o_y   (o_pos_y),
        .o_z   (o_pos_z)
    );

    assign o_valid    = r_vld[TOTAL-1];
    assign o_leg_echo = r_leg[TOTAL-1];

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while the result was stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
